// ----- hdl/float_precision_convert_top_macros.svh -----
// assertion macros for the precision converter
// FPC_ASSERT_IMP: same-cycle implication, FPC_ASSERT_NXT: next-cycle implication
// both sample on the rising edge of clk and are off while rst is high
`ifndef FLOAT_PRECISION_CONVERT_TOP_MACROS_SVH
`define FLOAT_PRECISION_CONVERT_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define FPC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fpc assertion failed");
`define FPC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fpc assertion failed");
`else
`define FPC_ASSERT_IMP(lbl, ante, cons)
`define FPC_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- hdl/fpc_pkg.sv -----
package fpc_pkg;

  // operation select carried with each transaction
  typedef enum logic {
    REQ_PROMOTE = 1'b0,
    REQ_DEMOTE  = 1'b1
  } req_t;

  localparam logic [63:0] QNAN64    = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] INF64     = 64'h7FF0_0000_0000_0000;
  localparam logic [31:0] QNAN32    = 32'h7FC0_0000;
  localparam logic [31:0] INF32     = 32'h7F80_0000;

  // binary64 bias minus binary32 bias
  localparam logic [10:0] EXP_OFFSET = 11'd896;
  // fraction width difference between the two formats
  localparam logic [5:0]  MANT_GAP   = 6'd29;
  // below this binary64 exponent the value is under half the smallest subnormal
  localparam logic [10:0] EXP_TINY   = 11'd873;
  // right shift for subnormal results is SUB_SHIFT_BASE minus the exponent
  localparam logic [10:0] SUB_SHIFT_BASE = 11'd926;
  // binary64 exponent of a normalized binary32 subnormal is PROMOTE_SUB_BASE - lz
  localparam logic [10:0] PROMOTE_SUB_BASE = 11'd897;
  localparam logic [11:0] EXP32_MAX  = 12'd255;

endpackage

// ----- hdl/float_precision_convert_top.sv -----
// ieee-754 binary32 <-> binary64 precision converter
//
// input channel: in_valid / in_stall with fields req_type and operand.
//   req_type 0 promotes the binary32 word in operand[31:0] to binary64,
//   req_type 1 demotes the binary64 operand to binary32 (round to nearest
//   even, subnormal results, overflow to infinity, nan to quiet nan).
// output channel: out_valid / out_stall with field value_out.
//   a demote result sits in value_out[31:0] with the upper half zero.
// a transaction is taken on a rising edge where valid is high and stall low.
//
// an accepted input passes the input register, then the result register,
//   before out_valid shows its result, and a receiver stall can hold it in
//   either; the conversion is one combinational pass between the two
//   registers.
// throughput: one transaction per cycle, limited only by the output side.
// when the receiver stalls, the result register holds and the input
//   register still takes one more transaction; in_stall rises only when both
//   registers are full and out_stall is high.
// reset (rst, synchronous, active high) empties both stages; no payload
//   state survives or matters, the converter keeps no state between items.
module float_precision_convert_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic [63:0] operand,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] value_out
);
  import fpc_pkg::*;

  `include "float_precision_convert_top_macros.svh"

  // input register stage
  logic        s1_valid;
  req_t        s1_req;
  logic [63:0] s1_operand;

  // result register stage
  logic        s2_valid;
  logic [63:0] s2_value;

  logic s1_load;
  logic s2_load;

  // promote path
  logic        p_sign;
  logic [7:0]  p_exp;
  logic [22:0] p_man;
  logic [4:0]  p_lz;
  logic [22:0] p_norm;
  logic [10:0] p_exp64;
  logic [63:0] p_result;

  // demote path
  logic        d_sign;
  logic [10:0] d_exp;
  logic [51:0] d_man;
  logic [52:0] d_sig;
  logic        d_normal;
  logic        d_tiny;
  logic [5:0]  d_sh;
  logic [5:0]  d_sh_low;
  logic [23:0] d_q;
  logic        d_guard;
  logic        d_sticky;
  logic [24:0] d_qr;
  logic [11:0] d_exp32;
  logic [22:0] d_mant32;
  logic [31:0] d_result;

  logic [63:0] value_next;

  // handshake: result stage moves when empty or drained, input stage moves
  // when empty or when its item goes to the result stage
  assign s2_load  = !s2_valid || !out_stall;
  assign s1_load  = !s1_valid || s2_load;
  assign in_stall = !s1_load;

  assign out_valid = s2_valid;
  assign value_out = s2_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid <= in_valid;
      end
      if (s2_load) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      s1_req     <= req_t'(req_type);
      s1_operand <= operand;
    end
    if (s2_load && s1_valid) begin
      s2_value <= value_next;
    end
  end

  // ---------------- promote binary32 -> binary64 ----------------
  assign p_sign = s1_operand[31];
  assign p_exp  = s1_operand[30:23];
  assign p_man  = s1_operand[22:0];

  // shift count that brings the leading one of a subnormal fraction to the
  // implicit bit position
  always_comb begin
    p_lz = 5'd0;
    for (int i = 0; i < 23; i++) begin
      if (p_man[i]) begin
        p_lz = 5'(23 - i);
      end
    end
  end

  assign p_norm = p_man << p_lz;

  always_comb begin
    p_exp64  = 11'(p_exp) + EXP_OFFSET;
    p_result = {p_sign, p_exp64, p_man, 29'd0};
    if (p_exp == 8'hFF) begin
      p_result = (p_man != 23'd0) ? QNAN64 : ({p_sign, 63'd0} | INF64);
    end else if (p_exp == 8'd0) begin
      if (p_man == 23'd0) begin
        p_result = {p_sign, 63'd0};
      end else begin
        p_exp64  = PROMOTE_SUB_BASE - 11'(p_lz);
        p_result = {p_sign, p_exp64, p_norm, 29'd0};
      end
    end
  end

  // ---------------- demote binary64 -> binary32 ----------------
  assign d_sign   = s1_operand[63];
  assign d_exp    = s1_operand[62:52];
  assign d_man    = s1_operand[51:0];
  assign d_sig    = {1'b1, d_man};
  assign d_normal = d_exp > EXP_OFFSET;
  assign d_tiny   = d_exp < EXP_TINY;

  // normal results drop the fraction gap, subnormal results shift further;
  // the subnormal shift lies between 30 and 53 whenever it is used
  assign d_sh     = d_normal ? MANT_GAP : 6'(SUB_SHIFT_BASE - d_exp);
  assign d_sh_low = d_sh - 6'd1;

  assign d_q      = 24'(d_sig >> d_sh);
  assign d_guard  = d_sig[d_sh_low];
  assign d_sticky = |(d_sig & ~({53{1'b1}} << d_sh_low));

  // round to nearest, ties to even
  assign d_qr = {1'b0, d_q} + 25'(d_guard & (d_sticky | d_q[0]));

  // carry out of the significand bumps the exponent
  assign d_exp32  = 12'(d_exp) - 12'(EXP_OFFSET) + 12'(d_qr[24]);
  assign d_mant32 = d_qr[24] ? d_qr[23:1] : d_qr[22:0];

  always_comb begin
    if (d_exp == 11'h7FF) begin
      d_result = (d_man != 52'd0) ? QNAN32 : ({d_sign, 31'd0} | INF32);
    end else if (d_tiny) begin
      // zero, binary64 subnormal, or below half the smallest subnormal
      d_result = {d_sign, 31'd0};
    end else if (d_normal) begin
      if (d_exp32 >= EXP32_MAX) begin
        d_result = {d_sign, 31'd0} | INF32;
      end else begin
        d_result = {d_sign, d_exp32[7:0], d_mant32};
      end
    end else begin
      // subnormal: a rounding carry into bit 23 lands on the exponent lsb
      d_result = {d_sign, 7'd0, d_qr[23:0]};
    end
  end

  assign value_next = (s1_req == REQ_DEMOTE) ? {32'd0, d_result} : p_result;

  // ---------------- checks ----------------
  `FPC_ASSERT_NXT(a_in_taken, in_valid && !in_stall, s1_valid)
  `FPC_ASSERT_IMP(a_stall_full, in_stall, s1_valid && s2_valid && out_stall)
  `FPC_ASSERT_NXT(a_advance, s1_valid && !out_stall, out_valid)
  `FPC_ASSERT_NXT(a_hold_input, s1_valid && in_stall,
                  s1_valid && $stable(s1_operand) && $stable(s1_req))
  `FPC_ASSERT_NXT(a_drain, out_valid && !out_stall && !s1_valid, !out_valid)

endmodule
